>>> sv/utdr_pkg.sv
// Shared types and constants for the transmit ring buffer.
// No dependencies; every other file except utdr_ram refers to this package by scoped names.
`default_nettype none
package utdr_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LEN_W = PTR_W + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam ptr_t DEPTH_M1  = PTR_W'(DEPTH - 1);
  localparam len_t DEPTH_LEN = LEN_W'(DEPTH);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_DONE  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] KIND_END  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  byte_value;
    logic [15:0] message_length;
    logic        last_of_message;
    logic [9:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic        dma_start;
    logic [9:0]  dma_index;
    logic [10:0] dma_length;
    logic [7:0]  read_data;
  } out_word_t;

  typedef struct packed {
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
  } ctrl_status_t;

endpackage
`default_nettype wire

>>> sv/utdr_in_if.sv
// Input channel interface: valid/ready handshake carrying one input word.
// Depends on utdr_pkg for the payload type.
`default_nettype none
interface utdr_in_if;
  logic              valid;
  logic              ready;
  utdr_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/utdr_out_if.sv
// Result channel interface: valid/ready handshake carrying one result word.
// Depends on utdr_pkg for the payload type.
`default_nettype none
interface utdr_out_if;
  logic               valid;
  logic               ready;
  utdr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/uart_tx_dma_ring_buffer.sv
// Top level of the transmit ring buffer: wires the controller and datapath.
// Depends on utdr_pkg, utdr_in_if, utdr_out_if, utdr_ctrl and utdr_dp.
//
//   Port    Dir  Carries
//   in_ch   in   action, byte_value, message_length, last_of_message, read_index
//   out_ch  out  kind, accepted, dma_start, dma_index, dma_length, read_data
//
// A word with a result shows it on the next cycle.
// The single result register frees as it is taken, so one word per cycle is
// sustained while the result side is ready.
// A result left waiting stalls every input word until it is taken.
// Reset is synchronous and active low; the ring contents are not cleared.
`default_nettype none
module uart_tx_dma_ring_buffer (
  input wire logic clk,
  input wire logic rst_n,
  utdr_in_if.sink  in_ch,
  utdr_out_if.source out_ch
);

  utdr_pkg::ctrl_cmd_t    cmd;
  utdr_pkg::ctrl_status_t status;

  utdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  utdr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_ch.data)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while a result is held");

  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.dma_start) |-> (out_ch.data.dma_length != 11'd0))
    else $error("transfer started with zero length");

  a_read_nostart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.kind == utdr_pkg::KIND_READ) |-> !out_ch.data.dma_start)
    else $error("read result carries a transfer start");

  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.action == utdr_pkg::ACT_NONE)
      |=> !out_ch.valid)
    else $error("ignored action produced a result");

endmodule
`default_nettype wire

>>> sv/utdr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module utdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/utdr_ctrl.sv
// Handshake controller: accepts a word while the result register is free or being emptied.
// Depends on utdr_pkg for command and status types.
`default_nettype none
module utdr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire utdr_pkg::ctrl_status_t status,
  output utdr_pkg::ctrl_cmd_t        cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_OUT  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready     = (state_r == S_IDLE) || out_ready;
  assign out_valid    = (state_r == S_OUT);
  assign cmd.exec     = in_valid && in_ready;
  assign cmd.load_out = cmd.exec && status.has_result;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load_out) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready && !cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/utdr_dp.sv
// Datapath: ring storage, pointers, message and transfer state, result register.
// Depends on utdr_pkg and utdr_ram.
`default_nettype none
module utdr_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire utdr_pkg::in_word_t    in_data,
  input  wire utdr_pkg::ctrl_cmd_t   cmd,
  output utdr_pkg::ctrl_status_t     status,
  output utdr_pkg::out_word_t        out_data
);

  utdr_pkg::ptr_t wp_r, wp_nxt, rp_r, rp_nxt;
  utdr_pkg::len_t infl_r, infl_nxt;
  logic busy_r, busy_nxt, open_r, open_nxt, dropped_r, dropped_nxt;

  logic [1:0]  kind_r;
  logic        acc_r, start_r;
  logic [9:0]  idx_r;
  logic [10:0] len_r;
  logic [7:0]  ram_q;

  logic is_wr, is_done, is_rd, last;
  utdr_pkg::ptr_t used, free_sp, wp_inc, wp_s, rp_s, rp_adv;
  logic too_big, first, store, full, dropped_pre, dropped_post, do_write;
  logic busy_s, try_en, start;
  utdr_pkg::len_t n_len;

  assign is_wr   = (in_data.action == utdr_pkg::ACT_WRITE);
  assign is_done = (in_data.action == utdr_pkg::ACT_DONE);
  assign is_rd   = (in_data.action == utdr_pkg::ACT_READ);
  assign last    = in_data.last_of_message;

  assign status.has_result = (is_wr && last) || is_done || is_rd;

  assign used    = wp_r - rp_r;
  assign free_sp = utdr_pkg::DEPTH_M1 - used;
  assign too_big = 32'(in_data.message_length) > 32'(free_sp);

  assign first        = !open_r;
  assign dropped_pre  = first ? too_big : dropped_r;
  assign store        = !(first && (in_data.message_length == 16'd0) && last);
  assign wp_inc       = wp_r + utdr_pkg::PTR_W'(1);
  assign full         = (wp_inc == rp_r);
  assign do_write     = is_wr && store && !dropped_pre && !full;
  assign dropped_post = dropped_pre || (store && !dropped_pre && full);

  assign rp_adv = rp_r + utdr_pkg::PTR_W'(infl_r);
  assign wp_s   = do_write ? wp_inc : wp_r;
  assign rp_s   = is_done ? rp_adv : rp_r;
  assign busy_s = is_done ? 1'b0 : busy_r;
  assign try_en = (is_wr && last) || (is_done && !open_r);
  assign start  = try_en && !busy_s && (wp_s != rp_s);
  assign n_len  = (wp_s > rp_s) ? utdr_pkg::LEN_W'(wp_s - rp_s)
                                : utdr_pkg::DEPTH_LEN - {1'b0, rp_s};

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    infl_nxt    = infl_r;
    busy_nxt    = busy_r;
    open_nxt    = open_r;
    dropped_nxt = dropped_r;
    if (cmd.exec) begin
      if (is_wr) begin
        wp_nxt      = wp_s;
        open_nxt    = !last;
        dropped_nxt = dropped_post;
      end
      if (is_done) begin
        rp_nxt   = rp_adv;
        busy_nxt = 1'b0;
        infl_nxt = '0;
      end
      if (start) begin
        busy_nxt = 1'b1;
        infl_nxt = n_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      infl_r    <= '0;
      busy_r    <= 1'b0;
      open_r    <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      infl_r    <= infl_nxt;
      busy_r    <= busy_nxt;
      open_r    <= open_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind_r  <= in_data.action;
      acc_r   <= is_wr && !dropped_post;
      start_r <= start;
      idx_r   <= start ? 10'(rp_s) : 10'd0;
      len_r   <= start ? 11'(n_len) : 11'd0;
    end
  end

  utdr_ram #(
    .WIDTH(8),
    .DEPTH(utdr_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && do_write),
    .waddr (wp_r),
    .wdata (in_data.byte_value),
    .re    (cmd.exec && is_rd),
    .raddr (utdr_pkg::PTR_W'(in_data.read_index)),
    .rdata (ram_q)
  );

  assign out_data.kind       = kind_r;
  assign out_data.accepted   = acc_r;
  assign out_data.dma_start  = start_r;
  assign out_data.dma_index  = idx_r;
  assign out_data.dma_length = len_r;
  assign out_data.read_data  = (kind_r == utdr_pkg::KIND_READ) ? ram_q : 8'd0;

endmodule
`default_nettype wire

>>> sim/uart_tx_dma_ring_buffer_test.sv
// Self-checking testbench for the transmit ring buffer: directed table, flood and random words.
// Depends on utdr_pkg, utdr_in_if, utdr_out_if and the uart_tx_dma_ring_buffer top level.
`default_nettype none
module uart_tx_dma_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    SHP_EXACT, SHP_EMPTY, SHP_ZERO_DECL, SHP_EDGE, SHP_HUGE, SHP_OVER, SHP_LONG
  } shape_t;

  typedef struct {
    utdr_pkg::in_word_t  w;
    bit                  typed;
    bit                  has;
    utdr_pkg::out_word_t r;
  } dir_row_t;

  logic clk;
  logic rst_n;

  utdr_in_if  in_ch ();
  utdr_out_if out_ch ();

  uart_tx_dma_ring_buffer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Ring state as the block should hold it.
  logic [7:0]     ring_mem [utdr_pkg::DEPTH];
  bit             stored_once [utdr_pkg::DEPTH];
  utdr_pkg::ptr_t wr_ptr;
  utdr_pkg::ptr_t rd_ptr;
  utdr_pkg::ptr_t last_stored;
  bit             busy;
  utdr_pkg::len_t inflight;
  bit             msg_open;
  bit             msg_drop;

  utdr_pkg::out_word_t ring_replies [$];
  dir_row_t            dir_tab [$];

  int errors = 0;
  int n_words = 0;
  int n_counted = 0;
  int n_results = 0;
  int n_starts = 0;
  int n_drops = 0;
  bit tx_calm = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("uart_tx_dma_ring_buffer: mismatch");
    $finish;
  end

  function automatic int ring_free();
    return utdr_pkg::DEPTH - 1 - int'(utdr_pkg::ptr_t'(wr_ptr - rd_ptr));
  endfunction

  task automatic launch(output bit st, output utdr_pkg::ptr_t sidx,
                        output utdr_pkg::len_t slen);
    st = 1'b0;
    sidx = '0;
    slen = '0;
    if (!busy && wr_ptr != rd_ptr) begin
      if (wr_ptr > rd_ptr) slen = utdr_pkg::len_t'(wr_ptr) - utdr_pkg::len_t'(rd_ptr);
      else slen = utdr_pkg::DEPTH_LEN - utdr_pkg::len_t'(rd_ptr);
      inflight = slen;
      busy = 1'b1;
      sidx = rd_ptr;
      st = 1'b1;
    end
  endtask

  task automatic ring_step(input utdr_pkg::in_word_t w, output bit has,
                           output utdr_pkg::out_word_t r);
    bit             keep;
    bit             st;
    utdr_pkg::ptr_t nxt;
    utdr_pkg::ptr_t sidx;
    utdr_pkg::len_t slen;
    r = '0;
    has = 1'b0;
    case (w.action)
      utdr_pkg::ACT_WRITE: begin
        keep = 1'b1;
        if (!msg_open) begin
          msg_open = 1'b1;
          msg_drop = int'(w.message_length) > ring_free();
          if (w.message_length == 16'd0 && w.last_of_message) keep = 1'b0;
        end
        if (keep && !msg_drop) begin
          nxt = wr_ptr + utdr_pkg::ptr_t'(1);
          if (nxt == rd_ptr) begin
            msg_drop = 1'b1;
          end else begin
            ring_mem[wr_ptr] = w.byte_value;
            stored_once[wr_ptr] = 1'b1;
            last_stored = wr_ptr;
            wr_ptr = nxt;
          end
        end
        if (w.last_of_message) begin
          msg_open = 1'b0;
          launch(st, sidx, slen);
          r.kind = utdr_pkg::KIND_END;
          r.accepted = !msg_drop;
          r.dma_start = st;
          r.dma_index = sidx;
          r.dma_length = slen;
          has = 1'b1;
        end
      end
      utdr_pkg::ACT_DONE: begin
        busy = 1'b0;
        rd_ptr = rd_ptr + utdr_pkg::ptr_t'(inflight);
        inflight = '0;
        st = 1'b0;
        sidx = '0;
        slen = '0;
        if (!msg_open) launch(st, sidx, slen);
        r.kind = utdr_pkg::KIND_DONE;
        r.dma_start = st;
        r.dma_index = sidx;
        r.dma_length = slen;
        has = 1'b1;
      end
      utdr_pkg::ACT_READ: begin
        r.kind = utdr_pkg::KIND_READ;
        r.read_data = ring_mem[w.read_index];
        has = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic utdr_pkg::in_word_t mk_in(logic [1:0] a, logic [7:0] b, logic [15:0] l,
                                               logic fin, logic [9:0] ri);
    utdr_pkg::in_word_t w;
    w.action = a;
    w.byte_value = b;
    w.message_length = l;
    w.last_of_message = fin;
    w.read_index = ri;
    return w;
  endfunction

  function automatic utdr_pkg::out_word_t mk_out(logic [1:0] k, logic acc, logic st,
                                                 logic [9:0] idx, logic [10:0] len,
                                                 logic [7:0] d);
    utdr_pkg::out_word_t r;
    r.kind = k;
    r.accepted = acc;
    r.dma_start = st;
    r.dma_index = idx;
    r.dma_length = len;
    r.read_data = d;
    return r;
  endfunction

  function automatic dir_row_t typed_row(utdr_pkg::in_word_t w, bit has,
                                         utdr_pkg::out_word_t r);
    dir_row_t row;
    row.w = w;
    row.typed = 1'b1;
    row.has = has;
    row.r = r;
    return row;
  endfunction

  function automatic dir_row_t open_row(utdr_pkg::in_word_t w);
    dir_row_t row;
    row.w = w;
    row.typed = 1'b0;
    row.has = 1'b0;
    row.r = '0;
    return row;
  endfunction

  function automatic int pick_gap();
    if (tx_calm || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offers one word, waits for the handshake and records what it should cause.
  task automatic send_word(input utdr_pkg::in_word_t w, input bit typed = 1'b0,
                           input bit t_has = 1'b0, input utdr_pkg::out_word_t t_r = '0);
    bit                  has;
    utdr_pkg::out_word_t r;
    int                  gap;
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ring_step(w, has, r);
    if (typed) begin
      has = t_has;
      r = t_r;
    end
    if (has) ring_replies.push_back(r);
    n_words++;
    if (w.action != utdr_pkg::ACT_NONE) n_counted++;
    if (n_words % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [9:0] pick_read_index();
    logic [9:0] idx;
    idx = 10'($urandom_range(0, utdr_pkg::DEPTH - 1));
    if (!stored_once[idx]) idx = last_stored;
    return idx;
  endfunction

  task automatic send_done();
    send_word(mk_in(utdr_pkg::ACT_DONE, 8'($urandom), 16'($urandom), 1'($urandom),
                    10'($urandom)));
  endtask

  task automatic send_read();
    send_word(mk_in(utdr_pkg::ACT_READ, 8'($urandom), 16'($urandom), 1'($urandom),
                    pick_read_index()));
  endtask

  task automatic send_message(input int decl, input int nbytes, input bit noisy);
    int         total;
    bit         fin;
    logic [15:0] l;
    total = (nbytes == 0) ? 1 : nbytes;
    for (int i = 0; i < total; i++) begin
      fin = (i == total - 1);
      l = (i == 0) ? 16'(decl) : 16'($urandom);
      send_word(mk_in(utdr_pkg::ACT_WRITE, 8'($urandom), l, fin, 10'($urandom)));
      if (noisy && !fin && $urandom_range(0, 9) == 0) send_done();
      if (noisy && !fin && $urandom_range(0, 19) == 0) send_read();
    end
  endtask

  task automatic send_random_message();
    shape_t shp;
    int     p;
    int     n;
    p = $urandom_range(0, 99);
    if (p < 40) shp = SHP_EXACT;
    else if (p < 48) shp = SHP_EMPTY;
    else if (p < 55) shp = SHP_ZERO_DECL;
    else if (p < 68) shp = SHP_EDGE;
    else if (p < 78) shp = SHP_HUGE;
    else if (p < 90) shp = SHP_OVER;
    else shp = SHP_LONG;
    case (shp)
      SHP_EXACT: begin
        n = $urandom_range(1, 6);
        send_message(n, n, 1'b1);
      end
      SHP_EMPTY: send_message(0, 0, 1'b0);
      SHP_ZERO_DECL: send_message(0, $urandom_range(1, 4), 1'b1);
      SHP_EDGE: send_message(ring_free() + $urandom_range(0, 1), $urandom_range(1, 3), 1'b1);
      SHP_HUGE: send_message($urandom_range(0, 65535), $urandom_range(1, 4), 1'b1);
      SHP_OVER: send_message(1, $urandom_range(2, 6), 1'b1);
      default: begin
        n = $urandom_range(10, 40);
        send_message(n, n, 1'b1);
      end
    endcase
  endtask

  task automatic cmp(input string nm, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, nm, want, got);
    end
  endtask

  task automatic check_reply(input utdr_pkg::out_word_t got);
    utdr_pkg::out_word_t want;
    n_results++;
    if (got.dma_start) n_starts++;
    if (got.kind == utdr_pkg::KIND_END && !got.accepted) n_drops++;
    if (ring_replies.size() == 0) begin
      errors++;
      $display("%0t unexpected result word: expected none, got %h", $time, got);
    end else begin
      want = ring_replies.pop_front();
      cmp("kind", want.kind, got.kind);
      cmp("accepted", want.accepted, got.accepted);
      cmp("dma_start", want.dma_start, got.dma_start);
      cmp("dma_index", want.dma_index, got.dma_index);
      cmp("dma_length", want.dma_length, got.dma_length);
      cmp("read_data", want.read_data, got.read_data);
    end
  endtask

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    int  hold_left;
    int  cyc;
    bit  rx_calm;
    bit  long_done;
    hold_left = 0;
    cyc = 0;
    rx_calm = 1'b0;
    long_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_ch.valid && out_ch.ready) check_reply(out_ch.data);
      if (cyc % 128 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (!long_done && n_results >= 30) begin
        long_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(10, 40) - 1;
        else hold_left = $urandom_range(1, 3) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int start_cnt;
    bit paused;
    int p;
    wr_ptr = '0;
    rd_ptr = '0;
    last_stored = '0;
    busy = 1'b0;
    inflight = '0;
    msg_open = 1'b0;
    msg_drop = 1'b0;
    paused = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_n = 1'b0;

    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_DONE, 8'h00, 16'h0000, 1'b0, 10'h000), 1'b1,
        mk_out(utdr_pkg::KIND_DONE, 1'b0, 1'b0, 10'd0, 11'd0, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_NONE, 8'hFF, 16'hFFFF, 1'b1, 10'h3FF), 1'b0, '0));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'hFF, 16'd0, 1'b1, 10'h3FF), 1'b1,
        mk_out(utdr_pkg::KIND_END, 1'b1, 1'b0, 10'd0, 11'd0, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'hFF, 16'd3, 1'b0, 10'h000), 1'b0, '0));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'h00, 16'hFFFF, 1'b0, 10'h3FF), 1'b0, '0));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'hA5, 16'h0000, 1'b1, 10'h000), 1'b1,
        mk_out(utdr_pkg::KIND_END, 1'b1, 1'b1, 10'd0, 11'd3, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_READ, 8'hFF, 16'hFFFF, 1'b1, 10'd0), 1'b1,
        mk_out(utdr_pkg::KIND_READ, 1'b0, 1'b0, 10'd0, 11'd0, 8'hFF)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_READ, 8'h00, 16'h0000, 1'b0, 10'd2), 1'b1,
        mk_out(utdr_pkg::KIND_READ, 1'b0, 1'b0, 10'd0, 11'd0, 8'hA5)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'h5A, 16'hFFFF, 1'b0, 10'h000), 1'b0, '0));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'h5A, 16'h0001, 1'b1, 10'h000), 1'b1,
        mk_out(utdr_pkg::KIND_END, 1'b0, 1'b0, 10'd0, 11'd0, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'h11, 16'd2, 1'b0, 10'h000), 1'b0, '0));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_DONE, 8'h00, 16'h0000, 1'b0, 10'h000), 1'b1,
        mk_out(utdr_pkg::KIND_DONE, 1'b0, 1'b0, 10'd0, 11'd0, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_WRITE, 8'h22, 16'h0000, 1'b1, 10'h000), 1'b1,
        mk_out(utdr_pkg::KIND_END, 1'b1, 1'b1, 10'd3, 11'd2, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_DONE, 8'hFF, 16'hFFFF, 1'b1, 10'h3FF), 1'b1,
        mk_out(utdr_pkg::KIND_DONE, 1'b0, 1'b0, 10'd0, 11'd0, 8'h00)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_DONE, 8'h00, 16'h0000, 1'b0, 10'h000), 1'b1,
        mk_out(utdr_pkg::KIND_DONE, 1'b0, 1'b0, 10'd0, 11'd0, 8'h00)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_READ, 8'h00, 16'h0000, 1'b0, 10'd4)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_WRITE, 8'h33, 16'd1, 1'b0, 10'h000)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_WRITE, 8'h44, 16'd0, 1'b0, 10'h000)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_WRITE, 8'h55, 16'd0, 1'b1, 10'h000)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_WRITE, 8'h66, 16'd0, 1'b0, 10'h000)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_WRITE, 8'h77, 16'd0, 1'b1, 10'h000)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_DONE, 8'h00, 16'h0000, 1'b0, 10'h000)));
    dir_tab.push_back(open_row(mk_in(utdr_pkg::ACT_READ, 8'h00, 16'h0000, 1'b0, 10'd9)));
    dir_tab.push_back(typed_row(
        mk_in(utdr_pkg::ACT_NONE, 8'h00, 16'h0000, 1'b0, 10'h000), 1'b0, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].has, dir_tab[i].r);

    // One oversized message overruns the ring, so later bytes are discarded.
    send_message(1, utdr_pkg::DEPTH + 8, 1'b0);
    send_read();
    send_done();

    start_cnt = n_counted;
    while (n_counted - start_cnt < 200) begin
      if (!paused && n_counted - start_cnt >= 100) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (ring_replies.size() > 0) @(posedge clk);
      end
      p = $urandom_range(0, 99);
      if (p < 55) send_random_message();
      else if (p < 77) send_done();
      else if (p < 95) send_read();
      else send_word(mk_in(utdr_pkg::ACT_NONE, 8'($urandom), 16'($urandom), 1'($urandom),
                           10'($urandom)));
    end

    in_ch.valid <= 1'b0;
    for (int k = 0; k < 20000 && ring_replies.size() > 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ring_replies.size() > 0) begin
      errors += ring_replies.size();
      $display("%0t %0d result words never arrived", $time, ring_replies.size());
    end

    $display("Sent %0d words (directed table, ring overrun, random messages and events).",
             n_words);
    $display("Checked %0d result words: %0d transfer starts, %0d dropped messages.",
             n_results, n_starts, n_drops);
    if (errors == 0) begin
      $display("uart_tx_dma_ring_buffer: match");
    end else begin
      $display("uart_tx_dma_ring_buffer: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
